// ===== design/prs_pkg.sv =====
// Shared constants and types for the panel refresh sequencer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package prs_pkg;

  localparam int MODE_W  = 3;
  localparam int CMD_W   = 3;
  localparam int PH_W    = 2;
  localparam int CFG_W   = 27;
  localparam int CIDX_W  = 2;
  localparam int EL_W    = 32;
  localparam int SEC_W   = 23;
  localparam int MSR_W   = 10;
  localparam int LEFT_W  = 17;

  // item kinds
  localparam logic [MODE_W-1:0] MODE_TICK   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_BEGIN  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_BYTE   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_COMMIT = 3'd3;
  localparam logic [MODE_W-1:0] MODE_ABORT  = 3'd4;

  // panel commands
  localparam logic [CMD_W-1:0] CMD_NONE    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_BEGIN   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_WRITE   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REFRESH = 3'd3;
  localparam logic [CMD_W-1:0] CMD_ABORT   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_SLEEP   = 3'd5;

  // phases
  localparam logic [PH_W-1:0] PH_IDLE    = 2'd0;
  localparam logic [PH_W-1:0] PH_UPLOAD  = 2'd1;
  localparam logic [PH_W-1:0] PH_REFRESH = 2'd2;
  localparam logic [PH_W-1:0] PH_COOL    = 2'd3;

  // register indexes
  localparam logic [CIDX_W-1:0] REG_COOLDOWN = 2'd0;
  localparam logic [CIDX_W-1:0] REG_TIMEOUT  = 2'd1;

  localparam logic [CFG_W-1:0] COOLDOWN_RST = 27'd60000;
  localparam logic [CFG_W-1:0] TIMEOUT_RST  = 27'd30000;

  // seconds/millisecond split of the 32-bit ms clock; 2^32-1 ms = 4294967 s + 295 ms
  localparam logic [MSR_W-1:0] MS_LAST  = 10'd999;
  localparam logic [SEC_W-1:0] SEC_WRAP = 23'd4294967;
  localparam logic [MSR_W-1:0] MSR_WRAP = 10'd295;

  // x/1000 == (x>>3)/125 == ((x>>3) * ceil(2^35/125)) >> 35, exact for x < 2^27
  localparam int RCP_W = 29;
  localparam logic [RCP_W-1:0] RCP_125 = 29'd274877907;
  localparam int RCP_SH = 35;
  localparam logic [LEFT_W-1:0] LEFT_MAX = 17'h1FFFF;

  typedef struct packed {
    logic              accepted;
    logic [CMD_W-1:0]  cmd;
    logic [7:0]        pbyte;
    logic              plast;
    logic [PH_W-1:0]   phase;
    logic              cool_act;
    logic [CFG_W-1:0]  cool_rem;
    logic              tmo_flag;
    logic [SEC_W-1:0]  finish_s;
  } prs_mid_t;

  typedef struct packed {
    logic              accepted;
    logic [CMD_W-1:0]  cmd;
    logic [7:0]        pbyte;
    logic              plast;
    logic [PH_W-1:0]   phase;
    logic [LEFT_W-1:0] cool_s;
    logic              tmo_flag;
    logic [SEC_W-1:0]  finish_s;
  } prs_out_t;

endpackage

`default_nettype wire

// ===== design/prs_ctrl.sv =====
// Phase decision and sequencer state; registers one result per item.
// Depends on prs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module prs_ctrl (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         go,
  input  wire  [prs_pkg::MODE_W-1:0]  mode,
  input  wire                         panel_busy,
  input  wire  [7:0]                  frame_byte,
  input  wire                         chunk_last,
  input  wire  [prs_pkg::CFG_W-1:0]   cool_time,
  input  wire  [prs_pkg::CFG_W-1:0]   timeout_ms,
  output prs_pkg::prs_mid_t           mid
);
  import prs_pkg::*;

  logic [PH_W-1:0]  phase, phase_next;
  logic [SEC_W-1:0] sec, sec_next;
  logic [MSR_W-1:0] msr, msr_next;
  // ms since commit / since refresh end; same as wrapped time differences
  logic [EL_W-1:0]  ref_el, ref_el_next;
  logic [EL_W-1:0]  cool_el, cool_el_next;
  logic [SEC_W-1:0] finish_s, finish_s_next;
  logic             tflag, tflag_next;
  logic             tmo_hit;
  prs_mid_t         res;

  always_comb begin
    phase_next    = phase;
    sec_next      = sec;
    msr_next      = msr;
    ref_el_next   = ref_el;
    cool_el_next  = cool_el;
    finish_s_next = finish_s;
    tflag_next    = tflag;
    tmo_hit       = 1'b0;
    res           = '0;

    unique case (mode)
      MODE_TICK: begin
        res.accepted = 1'b1;
        if (sec == SEC_WRAP && msr == MSR_WRAP) begin
          sec_next = '0;
          msr_next = '0;
        end else if (msr == MS_LAST) begin
          sec_next = sec + 1'b1;
          msr_next = '0;
        end else begin
          msr_next = msr + 1'b1;
        end
        ref_el_next  = ref_el + 1'b1;
        cool_el_next = cool_el + 1'b1;
        if (phase == PH_REFRESH) begin
          tmo_hit = ref_el_next >= {{(EL_W-CFG_W){1'b0}}, timeout_ms};
          if (!panel_busy || tmo_hit) begin
            res.cmd       = CMD_SLEEP;
            cool_el_next  = '0;
            finish_s_next = sec_next;
            tflag_next    = tmo_hit;
            phase_next    = PH_COOL;
          end
        end else if (phase == PH_COOL) begin
          if (cool_el_next >= {{(EL_W-CFG_W){1'b0}}, cool_time}) phase_next = PH_IDLE;
        end
      end
      MODE_BEGIN: begin
        if (phase == PH_IDLE) begin
          res.accepted = 1'b1;
          res.cmd      = CMD_BEGIN;
          phase_next   = PH_UPLOAD;
        end
      end
      MODE_BYTE: begin
        if (phase == PH_UPLOAD) begin
          res.accepted = 1'b1;
          res.cmd      = CMD_WRITE;
          res.pbyte    = frame_byte;
          res.plast    = chunk_last;
        end
      end
      MODE_COMMIT: begin
        if (phase == PH_UPLOAD) begin
          res.accepted = 1'b1;
          res.cmd      = CMD_REFRESH;
          ref_el_next  = '0;
          tflag_next   = 1'b0;
          phase_next   = PH_REFRESH;
        end
      end
      MODE_ABORT: begin
        if (phase == PH_UPLOAD) begin
          res.accepted = 1'b1;
          res.cmd      = CMD_ABORT;
          phase_next   = PH_IDLE;
        end
      end
      default: begin
      end
    endcase

    res.phase     = phase_next;
    res.cool_act  = (phase_next == PH_COOL) &&
                    (cool_el_next < {{(EL_W-CFG_W){1'b0}}, cool_time});
    res.cool_rem  = cool_time - cool_el_next[CFG_W-1:0];
    res.tmo_flag  = tflag_next;
    res.finish_s  = finish_s_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_IDLE;
      sec      <= '0;
      msr      <= '0;
      ref_el   <= '0;
      cool_el  <= '0;
      finish_s <= '0;
      tflag    <= 1'b0;
    end else if (go) begin
      phase    <= phase_next;
      sec      <= sec_next;
      msr      <= msr_next;
      ref_el   <= ref_el_next;
      cool_el  <= cool_el_next;
      finish_s <= finish_s_next;
      tflag    <= tflag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (go) mid <= res;
  end

endmodule

`default_nettype wire

// ===== design/prs_cdiv.sv =====
// Cooldown ms to whole seconds by reciprocal multiply, with saturation.
// Depends on prs_pkg; holds the output register of the top level.
`timescale 1ns / 1ps
`default_nettype none

module prs_cdiv (
  input  wire                     clk,
  input  wire                     load,
  input  wire prs_pkg::prs_mid_t  mid,
  output prs_pkg::prs_out_t       res
);
  import prs_pkg::*;

  localparam int Y_W = CFG_W - 3;
  localparam int P_W = Y_W + RCP_W;
  localparam int Q_W = P_W - RCP_SH;

  logic [P_W-1:0] prod;
  logic [Q_W-1:0] quot;
  logic [LEFT_W-1:0] secs;

  assign prod = P_W'(mid.cool_rem[CFG_W-1:3]) * P_W'(RCP_125);
  assign quot = prod[P_W-1:RCP_SH];

  always_comb begin
    if (!mid.cool_act) secs = '0;
    else if (quot > Q_W'(LEFT_MAX)) secs = LEFT_MAX;
    else secs = quot[LEFT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res.accepted  <= mid.accepted;
      res.cmd       <= mid.cmd;
      res.pbyte     <= mid.pbyte;
      res.plast     <= mid.plast;
      res.phase     <= mid.phase;
      res.cool_s    <= secs;
      res.tmo_flag  <= mid.tmo_flag;
      res.finish_s  <= mid.finish_s;
    end
  end

endmodule

`default_nettype wire

// ===== design/panel_refresh_sequencer.sv =====
// Panel refresh sequencer: input register, phase decision, seconds conversion, output.
// Results reach m_tvalid through three register stages (input, phase decision, output);
// throughput one item per cycle while m_tready is high.
// All stages hold under m_tready low; s_tready drops only when every stage is full.
// Reset (rst, synchronous): phase idle, clock and timers zero, registers to defaults,
// pipeline empty. No clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module panel_refresh_sequencer (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          s_tvalid,
  output logic                         s_tready,
  input  wire  [15:0]                  s_tdata,   // panel_busy, frame_byte[8:1], zero pad
  input  wire  [prs_pkg::MODE_W-1:0]   s_tuser,   // mode
  input  wire                          s_tlast,   // chunk_last
  output logic                         m_tvalid,
  input  wire                          m_tready,
  output logic [55:0]                  m_tdata,   // accepted, panel_byte, phase,
                                                  // cooldown_left_s, last_timed_out,
                                                  // last_refresh_uptime_s, zero pad
  output logic [prs_pkg::CMD_W-1:0]    m_tuser,   // panel_command
  output logic                         m_tlast,   // panel_byte_last
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire  [prs_pkg::CIDX_W-1:0]   cfg_index,
  input  wire  [prs_pkg::CFG_W-1:0]    cfg_data
);
  import prs_pkg::*;

  logic [CFG_W-1:0]  cool_time;
  logic [CFG_W-1:0]  timeout_ms;
  logic              in_v, mid_v, out_v;
  logic [MODE_W-1:0] in_mode;
  logic              in_busy;
  logic [7:0]        in_byte;
  logic              in_last;
  logic              out_ok, mid_ok, in_fire, in_go, mid_go;
  prs_mid_t          mid;
  prs_out_t          res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cool_time   <= COOLDOWN_RST;
      timeout_ms  <= TIMEOUT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_COOLDOWN: cool_time   <= cfg_data;
        REG_TIMEOUT:  timeout_ms  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign out_ok   = !out_v || m_tready;
  assign mid_ok   = !mid_v || out_ok;
  assign s_tready = !in_v || mid_ok;
  assign in_fire  = s_tvalid && s_tready;
  assign in_go    = in_v && mid_ok;
  assign mid_go   = mid_v && out_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v  <= 1'b0;
      mid_v <= 1'b0;
      out_v <= 1'b0;
    end else begin
      if (in_fire) in_v <= 1'b1;
      else if (in_go) in_v <= 1'b0;
      if (in_go) mid_v <= 1'b1;
      else if (mid_go) mid_v <= 1'b0;
      if (mid_go) out_v <= 1'b1;
      else if (m_tready) out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_mode <= s_tuser;
      in_busy <= s_tdata[0];
      in_byte <= s_tdata[8:1];
      in_last <= s_tlast;
    end
  end

  prs_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .go          (in_go),
    .mode        (in_mode),
    .panel_busy  (in_busy),
    .frame_byte  (in_byte),
    .chunk_last  (in_last),
    .cool_time   (cool_time),
    .timeout_ms  (timeout_ms),
    .mid         (mid)
  );

  prs_cdiv u_cdiv (
    .clk  (clk),
    .load (mid_go),
    .mid  (mid),
    .res  (res)
  );

  assign m_tvalid = out_v;
  assign m_tuser  = res.cmd;
  assign m_tlast  = res.plast;
  assign m_tdata  = {4'b0, res.finish_s, res.tmo_flag, res.cool_s, res.phase,
                     res.pbyte, res.accepted};

  // byte-last only travels with a write command
  a_last_write: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != CMD_WRITE |-> !m_tlast)
    else $error("tlast set on non-write result");

  // cooldown seconds only reported in cooldown phase
  a_cool_phase: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res.cool_s != '0 |-> res.phase == PH_COOL)
    else $error("cooldown left outside cooldown");

  // refresh end always lands in cooldown
  a_sleep_cool: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == CMD_SLEEP |-> res.phase == PH_COOL)
    else $error("sleep command without cooldown phase");

  // input stalls only when the whole pipeline is full and blocked
  a_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> in_v && mid_v && out_v && !m_tready)
    else $error("input stalled with room in pipeline");

endmodule

`default_nettype wire
